/* rtl/complex_magnitude_detect_defines.svh */
// Assertion macros shared by the complex magnitude detector RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_MAGNITUDE_DETECT_DEFINES_SVH
`define COMPLEX_MAGNITUDE_DETECT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define CMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define CMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/cmd_pkg.sv */
// Shared types and fixed constants for the complex magnitude detector.
// No dependencies; used by every module of the block.
`default_nettype none

package cmd_pkg;

    localparam int IN_W            = 16;
    localparam int SCALE_W         = 24;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int PIXEL_W         = 8;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX   = 8'd255;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // Per-stage control that travels beside the datapath.
    typedef struct packed {
        logic valid;
        logic last;
    } cmd_ctl_t;

endpackage

`default_nettype wire

/* rtl/complex_magnitude_detect.sv */
// Complex magnitude detector top level: front end, square root cell chain,
// gain stage and output skid buffer. Depends on cmd_pkg, cmd_sqrt_cell,
// cmd_scale_sat and complex_magnitude_detect_defines.svh.
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  I, Q sample, tlast = line end
//   m_axis    out        m_axis_tvalid / m_axis_tready  8-bit pixel, tlast = line end
//   cfg       in         cfg_wr_en (always taken)       24-bit Q8.16 scale factor
//
// One sample is taken per clock while the skid register is empty, and one pixel
// leaves per clock while m_axis_tready is high. Each pixel passes three front-end
// stages, one square root cell per root bit (16 + ROOT_FRAC_BITS), two gain stages
// and the output register. Reset clears every valid flag and sets the scale to 1.0.
// A stalled output parks one pixel in the skid register; the pipeline freezes
// only while that register is full, so s_axis_tready is a plain flop output.
`default_nettype none
`include "complex_magnitude_detect_defines.svh"

module complex_magnitude_detect #(
    parameter int ROOT_FRAC_BITS = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    // Input samples. tdata: [15:0] in_phase, [31:16] quadrature.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    // Output pixels. tdata: [7:0] pixel.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // Scale factor write, unsigned Q8.16.
    input  wire         cfg_wr_en,
    input  wire  [23:0] cfg_wr_data
);

    // Root has 16 integer bits plus the fractional bits; the radicand is the
    // 32-bit sum of squares shifted up by twice the fractional bits.
    localparam int ROOT_W = 16 + ROOT_FRAC_BITS;
    localparam int RAD_W  = 32 + 2 * ROOT_FRAC_BITS;
    localparam int ABS_W  = cmd_pkg::IN_W + 1;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int SQR_W  = 31;
    localparam int SUM_W  = 32;

    // The whole pipeline advances unless the skid register holds a pixel.
    logic en;

    logic [cmd_pkg::SCALE_W-1:0] scale_reg;

    // Front end: absolute values, squares, sum of squares.
    cmd_pkg::cmd_ctl_t  ctl1_reg, ctl1_next, ctl2_reg, ctl3_reg;
    logic signed [ABS_W-1:0] i_ext, q_ext;
    logic [ABS_W-1:0]   abs_i_reg, abs_i_next, abs_q_reg, abs_q_next;
    logic [SQ_W-1:0]    sq_i_full, sq_q_full;
    logic [SQR_W-1:0]   sq_i_reg, sq_q_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    always_comb
    begin
        i_ext      = {s_axis_tdata[15], s_axis_tdata[15:0]};
        q_ext      = {s_axis_tdata[31], s_axis_tdata[31:16]};
        abs_i_next = i_ext[ABS_W-1] ? ABS_W'(-i_ext) : ABS_W'(i_ext);
        abs_q_next = q_ext[ABS_W-1] ? ABS_W'(-q_ext) : ABS_W'(q_ext);
        ctl1_next.valid = s_axis_tvalid;
        ctl1_next.last  = s_axis_tlast;
        sq_i_full  = SQ_W'(abs_i_reg) * SQ_W'(abs_i_reg);
        sq_q_full  = SQ_W'(abs_q_reg) * SQ_W'(abs_q_reg);
        // Each square is at most 2^30, so the sum fits in 32 bits.
        sum_next   = SUM_W'(sq_i_reg) + SUM_W'(sq_q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= cmd_pkg::SCALE_RESET;
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            ctl3_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            if (en)
            begin
                ctl1_reg <= ctl1_next;
                ctl2_reg <= ctl1_reg;
                ctl3_reg <= ctl2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_i_reg <= abs_i_next;
            abs_q_reg <= abs_q_next;
            sq_i_reg  <= sq_i_full[SQR_W-1:0];
            sq_q_reg  <= sq_q_full[SQR_W-1:0];
            sum_reg   <= sum_next;
        end
    end

    // Square root: a chain of cells, each resolving one root bit from the top.
    cmd_pkg::cmd_ctl_t  ctl_a  [0:ROOT_W];
    logic [RAD_W-1:0]   rad_a  [0:ROOT_W];
    logic [ROOT_W+1:0]  rem_a  [0:ROOT_W];
    logic [ROOT_W-1:0]  root_a [0:ROOT_W];

    assign ctl_a[0]  = ctl3_reg;
    assign rad_a[0]  = RAD_W'(sum_reg) << (2 * ROOT_FRAC_BITS);
    assign rem_a[0]  = '0;
    assign root_a[0] = '0;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_cell
        cmd_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .RAD_W  (RAD_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_a[g]),
            .rad_in   (rad_a[g]),
            .rem_in   (rem_a[g]),
            .root_in  (root_a[g]),
            .ctl_out  (ctl_a[g+1]),
            .rad_out  (rad_a[g+1]),
            .rem_out  (rem_a[g+1]),
            .root_out (root_a[g+1])
        );
    end

    // Gain and saturation.
    cmd_pkg::cmd_ctl_t              sc_ctl;
    logic [cmd_pkg::PIXEL_W-1:0]    sc_pixel;

    cmd_scale_sat #(
        .ROOT_W    (ROOT_W),
        .FRAC_BITS (ROOT_FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_a[ROOT_W]),
        .mag_in    (root_a[ROOT_W]),
        .scale_in  (scale_reg),
        .ctl_out   (sc_ctl),
        .pixel_out (sc_pixel)
    );

    // Output register with a one-entry skid register behind it.
    logic                           out_valid_reg, out_valid_next;
    logic [cmd_pkg::PIXEL_W-1:0]    out_pixel_reg, out_pixel_next;
    logic                           out_last_reg,  out_last_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic [cmd_pkg::PIXEL_W-1:0]    skid_pixel_reg, skid_pixel_next;
    logic                           skid_last_reg,  skid_last_next;
    logic                           push, pop;

    assign en = !skid_valid_reg;

    always_comb
    begin
        push = en && sc_ctl.valid;
        pop  = out_valid_reg && m_axis_tready;

        out_valid_next  = out_valid_reg;
        out_pixel_next  = out_pixel_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_pixel_next = skid_pixel_reg;
        skid_last_next  = skid_last_reg;

        if (skid_valid_reg)
        begin
            // Pipeline is frozen; drain the parked pixel once the output frees up.
            if (pop)
            begin
                out_pixel_next  = skid_pixel_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_pixel_next = sc_pixel;
                out_last_next  = sc_ctl.last;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_pixel_next = sc_pixel;
                skid_last_next  = sc_ctl.last;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg  <= out_pixel_next;
        out_last_reg   <= out_last_next;
        skid_pixel_reg <= skid_pixel_next;
        skid_last_reg  <= skid_last_next;
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

    // The skid register is only ever filled behind an occupied output register.
    `CMD_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A pixel arriving at a blocked output must be parked, not dropped.
    `CMD_ASSERT_NEXT(a_skid_catches, clk, rst_n,
        push && out_valid_reg && !m_axis_tready, skid_valid_reg)
    // Draining the skid register keeps the output occupied.
    `CMD_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && pop,
        m_axis_tvalid && !skid_valid_reg)

endmodule

`default_nettype wire

/* rtl/cmd_sqrt_cell.sv */
// One cell of the digit-by-digit square root chain: resolves one root bit.
// Depends on cmd_pkg for the control struct.
`default_nettype none

module cmd_sqrt_cell #(
    parameter int ROOT_W = 24,
    parameter int RAD_W  = 48
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  cmd_pkg::cmd_ctl_t       ctl_in,
    input  wire  [RAD_W-1:0]        rad_in,
    input  wire  [ROOT_W+1:0]       rem_in,
    input  wire  [ROOT_W-1:0]       root_in,
    output cmd_pkg::cmd_ctl_t       ctl_out,
    output logic [RAD_W-1:0]        rad_out,
    output logic [ROOT_W+1:0]       rem_out,
    output logic [ROOT_W-1:0]       root_out
);

    cmd_pkg::cmd_ctl_t  ctl_reg;
    logic [RAD_W-1:0]   rad_reg,  rad_next;
    logic [ROOT_W+1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [ROOT_W+1:0]  rem_sh;
    logic [ROOT_W+1:0]  trial;
    logic               ge;

    // Bring down the next two radicand bits and try appending a one to the root.
    always_comb
    begin
        rem_sh    = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = rad_in << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

/* rtl/cmd_scale_sat.sv */
// Gain multiply and clamp: magnitude times Q8.16 scale, shift, saturate to 8 bits.
// Depends on cmd_pkg for widths, constants and the control struct.
`default_nettype none

module cmd_scale_sat #(
    parameter int ROOT_W    = 24,
    parameter int FRAC_BITS = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               en,
    input  cmd_pkg::cmd_ctl_t                 ctl_in,
    input  wire  [ROOT_W-1:0]                 mag_in,
    input  wire  [cmd_pkg::SCALE_W-1:0]       scale_in,
    output cmd_pkg::cmd_ctl_t                 ctl_out,
    output logic [cmd_pkg::PIXEL_W-1:0]       pixel_out
);

    localparam int PROD_W = ROOT_W + cmd_pkg::SCALE_W;
    localparam int SHIFT  = FRAC_BITS + cmd_pkg::SCALE_FRAC_BITS;
    localparam int HI_W   = PROD_W - SHIFT;

    cmd_pkg::cmd_ctl_t              ctl1_reg, ctl2_reg;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [HI_W-1:0]                hi;
    logic [cmd_pkg::PIXEL_W-1:0]    pixel_reg, pixel_next;

    always_comb
    begin
        prod_next  = PROD_W'(mag_in) * PROD_W'(scale_in);
        hi         = prod_reg[PROD_W-1:SHIFT];
        pixel_next = (|hi[HI_W-1:cmd_pkg::PIXEL_W]) ? cmd_pkg::PIXEL_MAX
                                                     : hi[cmd_pkg::PIXEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            pixel_reg <= pixel_next;
        end
    end

    assign ctl_out   = ctl2_reg;
    assign pixel_out = pixel_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the complex magnitude detector.
// Depends on cmd_pkg and the complex_magnitude_detect RTL; no other files.

module tb_top;

    localparam int IN_W            = cmd_pkg::IN_W;
    localparam int PIXEL_W         = cmd_pkg::PIXEL_W;
    localparam int SCALE_W         = cmd_pkg::SCALE_W;
    localparam int SCALE_FRAC_BITS = cmd_pkg::SCALE_FRAC_BITS;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX   = cmd_pkg::PIXEL_MAX;
    localparam logic [SCALE_W-1:0] SCALE_RESET = cmd_pkg::SCALE_RESET;

    localparam int ROOT_FRAC    = 8;
    // Sample-to-pixel latency given for the block.
    localparam int LATENCY      = 22 + ROOT_FRAC;
    // Cycles without any transfer, while work is outstanding, before the run is abandoned.
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 240;

    // One complex sample as the testbench sees it.
    typedef struct {
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
        logic                   eol;
    } sample_t;

    // One predicted pixel and its line end mark.
    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               eol;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [7:0]         m_axis_tdata;
    logic               m_axis_tlast;
    logic               cfg_wr_en;
    logic [23:0]        cfg_wr_data;

    // Samples waiting to be driven, and pixels the detector still owes us.
    sample_t            pending_samples[$];
    pixel_t             owed_pixels[$];

    // Testbench copy of the gain register, changed only while the detector is idle.
    logic [SCALE_W-1:0] gain_setting;
    // When set, neither side inserts idle cycles.
    logic               calm;
    logic               sample_taken;
    int                 mismatch_count;
    int                 quiet_cycles;

    complex_magnitude_detect #(
        .ROOT_FRAC_BITS (ROOT_FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Expected pixel for one sample at the given gain. The magnitude is the
    // integer square root of the sum of squares widened by twice the root's
    // fractional bits; it is found one result bit at a time from the top,
    // keeping each bit whose trial square still fits under the radicand.
    function automatic logic [PIXEL_W-1:0] predict_pixel(logic signed [IN_W-1:0] re,
                                                         logic signed [IN_W-1:0] im,
                                                         logic [SCALE_W-1:0] gain);
        logic signed [IN_W:0] wide_re;
        logic signed [IN_W:0] wide_im;
        logic [IN_W:0]        abs_re;
        logic [IN_W:0]        abs_im;
        logic [63:0]          radicand;
        logic [63:0]          root;
        logic [63:0]          trial;
        logic [63:0]          product;
        int                   b;
        wide_re  = re;
        wide_im  = im;
        abs_re   = (wide_re < 0) ? 17'(-wide_re) : 17'(wide_re);
        abs_im   = (wide_im < 0) ? 17'(-wide_im) : 17'(wide_im);
        radicand = 64'(abs_re) * 64'(abs_re) + 64'(abs_im) * 64'(abs_im);
        radicand = radicand << (2 * ROOT_FRAC);
        root     = 64'd0;
        for (b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        product = (root * 64'(gain)) >> (ROOT_FRAC + SCALE_FRAC_BITS);
        return (product > 64'(PIXEL_MAX)) ? PIXEL_MAX : product[PIXEL_W-1:0];
    endfunction

    // One random component. Raw full-range values alone would saturate almost
    // every pixel at unity gain, so half are shrunk by a random arithmetic shift or
    // drawn from a narrow band around zero, and a quarter are full-scale extremes.
    function automatic logic signed [IN_W-1:0] random_component();
        logic signed [IN_W-1:0] v;
        int                     kind;
        kind = $urandom_range(3);
        v    = IN_W'($urandom);
        if (kind == 1)
            v = v >>> $urandom_range(15);
        else if (kind == 2)
            v = IN_W'($urandom_range(128)) - 16'sd64;
        else if (kind == 3)
            v = ($urandom_range(1) == 1) ? -16'sd32768 : 16'sd32767;
        return v;
    endfunction

    task automatic queue_sample(input logic signed [IN_W-1:0] re,
                                input logic signed [IN_W-1:0] im,
                                input logic eol);
        sample_t s;
        s.re  = re;
        s.im  = im;
        s.eol = eol;
        pending_samples.push_back(s);
    endtask

    // Blocks until every queued sample is driven and every pixel has come back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || owed_pixels.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    // Gain writes happen only with the pipeline empty, so the prediction can
    // switch to the new value as soon as the write edge has passed.
    task automatic write_gain(input logic [SCALE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        gain_setting  = value;
    endtask

    // Input driver. A raised tvalid is held with its data until the transfer
    // completes; a new sample is only offered after that, or from idle, and
    // about three draws in ten leave the input idle unless the calm stretch is on. The
    // output side's tready is redrawn every cycle with the same odds.
    always @(negedge clk)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || sample_taken)
            begin
                if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 30))
                begin
                    nxt            = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.im, nxt.re};
                    s_axis_tlast  <= nxt.eol;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // Monitor. Outputs are checked before the new sample's prediction is
    // queued, so a stray pixel can never be matched against a sample that
    // only entered on the same edge. The watchdog counts edges without any
    // transfer while work is outstanding, including a sample still on offer.
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        logic   in_xfer;
        logic   out_xfer;
        in_xfer      = rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer     = rst_n && m_axis_tvalid && m_axis_tready;
        sample_taken <= in_xfer;

        if (out_xfer)
        begin
            got.pixel = m_axis_tdata;
            got.eol   = m_axis_tlast;
            if (owed_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected pixel, expected none, actual %0d tlast %0b",
                         $time, got.pixel, got.eol);
            end
            else
            begin
                want = owed_pixels.pop_front();
                if (got.pixel !== want.pixel)
                begin
                    mismatch_count++;
                    $display("%0t: pixel mismatch, expected %0d, actual %0d",
                             $time, want.pixel, got.pixel);
                end
                if (got.eol !== want.eol)
                begin
                    mismatch_count++;
                    $display("%0t: line end mismatch, expected %0b, actual %0b",
                             $time, want.eol, got.eol);
                end
            end
        end

        if (in_xfer)
        begin
            want.pixel = predict_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16], gain_setting);
            want.eol   = s_axis_tlast;
            owed_pixels.push_back(want);
        end

        if (in_xfer || out_xfer ||
            (pending_samples.size() == 0 && owed_pixels.size() == 0 && !s_axis_tvalid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("complex_magnitude_detect regression: fail");
            $finish;
        end
    end

    // Stimulus sequence: reset, a directed set at the reset gain, zero gain
    // and full gain, then random phases over a spread of gain settings.
    initial
    begin
        logic [SCALE_W-1:0] phase_gain[6];
        int                 p;
        int                 n;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        calm           = 1'b0;
        sample_taken   = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        gain_setting   = SCALE_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // At unity gain the pixel is the integer magnitude, so small vectors
        // show exact values while the full-scale corners saturate. The most
        // negative value appears on each axis and on both together.
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd3, 16'sd4, 1'b0);
        queue_sample(-16'sd1, -16'sd1, 1'b1);
        queue_sample(16'sd1, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sd1, 1'b0);
        queue_sample(16'sd255, 16'sd0, 1'b0);
        queue_sample(16'sd0, -16'sd256, 1'b1);
        queue_sample(16'sd180, 16'sd180, 1'b0);
        queue_sample(16'sd32767, 16'sd0, 1'b0);
        queue_sample(-16'sd32768, 16'sd0, 1'b0);
        queue_sample(16'sd0, -16'sd32768, 1'b0);
        queue_sample(-16'sd32768, -16'sd32768, 1'b1);
        queue_sample(16'sd32767, 16'sd32767, 1'b0);
        queue_sample(-16'sd32768, 16'sd32767, 1'b1);
        wait_drained();

        // Zero gain forces every pixel to zero, even at full-scale inputs.
        write_gain(24'd0);
        queue_sample(-16'sd32768, -16'sd32768, 1'b0);
        queue_sample(16'sd32767, 16'sd32767, 1'b1);
        queue_sample(16'sd100, -16'sd7, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b1);
        wait_drained();

        // Full gain: any nonzero vector reaches the maximum pixel; only the zero vector stays at zero.
        write_gain(24'hFFFFFF);
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sd1, 1'b1);
        queue_sample(-16'sd1, 16'sd0, 1'b0);
        queue_sample(-16'sd32768, -16'sd32768, 1'b1);
        wait_drained();

        phase_gain[0] = 24'h000100;
        phase_gain[1] = 24'hFFFFFF;
        phase_gain[2] = SCALE_RESET;
        phase_gain[3] = SCALE_W'($urandom);
        phase_gain[4] = SCALE_W'($urandom) >> $urandom_range(23);
        phase_gain[5] = 24'h000001;

        for (p = 0; p < 6; p++)
        begin
            write_gain(phase_gain[p]);
            // The unity-gain phase runs with both sides streaming flat out.
            calm = (p == 2);
            @(posedge clk);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_sample(random_component(), random_component(),
                             $urandom_range(7) == 0);
            wait_drained();
            calm = 1'b0;
        end

        // Give the pipeline time to show any pixel it should not produce.
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("complex_magnitude_detect regression: pass");
        else
            $display("complex_magnitude_detect regression: fail");
        $finish;
    end

endmodule
